// ===== hw/rtl/scct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package scct_pkg;

  localparam logic [1:0] CMD_ACCESS = 2'd0;
  localparam logic [1:0] CMD_FLUSH  = 2'd1;
  localparam logic [1:0] CMD_HALT   = 2'd2;

  localparam int unsigned WCNT_W = 8;
  localparam logic [WCNT_W-1:0] WCNT_MAX = 8'd255;
  localparam logic [WCNT_W-1:0] THRESH_RESET = 8'd50;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_VICTIM,
    ST_EMIT,
    ST_FSCAN,
    ST_FREAD,
    ST_FEND
  } scct_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/scct_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scct_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sector_cache_clock_tags_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Tag and clock-replacement engine for a fully associative sector cache. Sector
// tags sit in one RAM with a single read port, and the lookup reads it one slot
// per cycle; a miss on a full cache adds the hand sweep, one slot per cycle. A
// flush walks the slots one per cycle, stops on each dirty slot to read its tag,
// and can wait there while the result channel is held; it ends with a final
// transfer. Each transfer on the result channel has last set on the final
// result of its command. A command of 3 yields no result.
// The input is taken again as soon as the result is in the output register.
module sector_cache_clock_tags_top
  import scct_pkg::*;
#(
  parameter int unsigned CACHE_SLOTS = 64,
  parameter int unsigned SECTOR_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [WCNT_W-1:0]              cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     cmd,
  input  wire logic [SECTOR_BITS-1:0]         sector,
  input  wire logic                           is_write,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [$clog2(CACHE_SLOTS)-1:0]      slot,
  output logic                                hit,
  output logic                                writeback_valid,
  output logic [SECTOR_BITS-1:0]              writeback_sector,
  output logic                                flush_due,
  output logic                                last
);

  localparam int unsigned IDX_W = $clog2(CACHE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_SLOTS - 1);

  scct_state_t state, state_next;

  logic [CACHE_SLOTS-1:0] entry_valid;
  logic [CACHE_SLOTS-1:0] entry_reference;
  logic [CACHE_SLOTS-1:0] entry_dirty;
  logic [IDX_W-1:0]       clock_hand;
  logic [WCNT_W-1:0]      write_counter;
  logic [WCNT_W-1:0]      flush_threshold;

  logic [SECTOR_BITS-1:0] sector_q;
  logic                   wr_q;
  logic                   halt_q;
  logic [IDX_W-1:0]       scan_idx;
  logic                   issue_more;
  logic                   cmp_vld;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       slot_q;
  logic                   hit_q;
  logic                   wbv_q;
  logic [SECTOR_BITS-1:0] wbs_q;
  logic                   pend_vld;
  logic [IDX_W-1:0]       pend_slot;
  logic [SECTOR_BITS-1:0] pend_sector;

  logic                   ram_we;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [SECTOR_BITS-1:0] ram_rdata;

  logic                   out_free;
  logic                   out_load;
  logic                   cmp_match;
  logic                   cmp_end;
  logic                   free_any;
  logic [IDX_W-1:0]       free_pick;
  logic                   scan_dirty;
  logic [IDX_W-1:0]       hand_next;
  logic [WCNT_W-1:0]      wc_inc;
  logic                   due;

  scct_ram #(
    .WIDTH (SECTOR_BITS),
    .DEPTH (CACHE_SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_q),
    .wdata (sector_q),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready  = !rst;
  assign in_ready   = (state == ST_IDLE) && !rst;
  assign out_free   = !out_valid || out_ready;
  assign out_load   = out_free && ((state == ST_EMIT) || (state == ST_FEND) ||
                                   ((state == ST_FREAD) && pend_vld));
  assign cmp_match  = cmp_vld && entry_valid[cmp_idx] && (ram_rdata == sector_q);
  assign cmp_end    = cmp_vld && (cmp_idx == LAST_IDX);
  assign free_any   = free_found || !entry_valid[cmp_idx];
  assign free_pick  = free_found ? free_idx : cmp_idx;
  assign scan_dirty = entry_valid[scan_idx] && entry_dirty[scan_idx];
  assign hand_next  = (clock_hand == LAST_IDX) ? '0 : clock_hand + 1'b1;
  assign wc_inc     = (write_counter == WCNT_MAX) ? WCNT_MAX : write_counter + 1'b1;
  assign due        = wr_q && (wc_inc >= flush_threshold);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_ACCESS: state_next = ST_SCAN;
            CMD_FLUSH:  state_next = ST_FSCAN;
            CMD_HALT:   state_next = ST_FSCAN;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (cmp_match) begin
          state_next = ST_EMIT;
        end else if (cmp_end) begin
          state_next = free_any ? ST_EMIT : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!entry_reference[clock_hand]) begin
          state_next = ST_VICTIM;
        end
      end
      ST_VICTIM: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FSCAN: begin
        if (scan_dirty) begin
          state_next = ST_FREAD;
        end else if (scan_idx == LAST_IDX) begin
          state_next = ST_FEND;
        end
      end
      ST_FREAD: begin
        if (!pend_vld || out_free) begin
          state_next = (scan_idx == LAST_IDX) ? ST_FEND : ST_FSCAN;
        end
      end
      ST_FEND: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = scan_idx;
    ram_we    = 1'b0;
    case (state)
      ST_SCAN: ram_re = issue_more;
      ST_SWEEP: begin
        ram_re    = !entry_reference[clock_hand];
        ram_raddr = clock_hand;
      end
      ST_FSCAN: ram_re = scan_dirty;
      ST_EMIT:  ram_we = out_free && !hit_q;
      default: begin
        ram_re = 1'b0;
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      entry_valid     <= '0;
      entry_reference <= '0;
      entry_dirty     <= '0;
      clock_hand      <= '0;
      write_counter   <= '0;
      flush_threshold <= THRESH_RESET;
      out_valid       <= 1'b0;
      pend_vld        <= 1'b0;
      issue_more      <= 1'b0;
      cmp_vld         <= 1'b0;
      free_found      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        flush_threshold <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sector_q   <= sector;
            wr_q       <= is_write;
            halt_q     <= (cmd == CMD_HALT);
            scan_idx   <= '0;
            issue_more <= 1'b1;
            cmp_vld    <= 1'b0;
            free_found <= 1'b0;
            pend_vld   <= 1'b0;
          end
        end
        ST_SCAN: begin
          cmp_vld <= issue_more;
          cmp_idx <= scan_idx;
          if (issue_more) begin
            if (scan_idx == LAST_IDX) begin
              issue_more <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          if (cmp_vld && !free_found && !entry_valid[cmp_idx]) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          if (cmp_match) begin
            slot_q <= cmp_idx;
            hit_q  <= 1'b1;
            wbv_q  <= 1'b0;
            wbs_q  <= '0;
          end else if (cmp_end) begin
            slot_q <= free_pick;
            hit_q  <= 1'b0;
            wbv_q  <= 1'b0;
            wbs_q  <= '0;
          end
        end
        ST_SWEEP: begin
          clock_hand <= hand_next;
          if (entry_reference[clock_hand]) begin
            entry_reference[clock_hand] <= 1'b0;
          end else begin
            slot_q <= clock_hand;
          end
        end
        ST_VICTIM: begin
          wbv_q <= entry_dirty[slot_q];
          wbs_q <= entry_dirty[slot_q] ? ram_rdata : '0;
        end
        ST_EMIT: begin
          if (out_free) begin
            slot             <= slot_q;
            hit              <= hit_q;
            writeback_valid  <= wbv_q;
            writeback_sector <= wbs_q;
            flush_due        <= due;
            last             <= 1'b1;
            entry_valid[slot_q]     <= 1'b1;
            entry_reference[slot_q] <= 1'b1;
            entry_dirty[slot_q]     <= hit_q ? (entry_dirty[slot_q] | wr_q) : wr_q;
            if (wr_q) begin
              write_counter <= due ? '0 : wc_inc;
            end
          end
        end
        ST_FSCAN: begin
          if (scan_dirty) begin
            entry_dirty[scan_idx] <= 1'b0;
            slot_q                <= scan_idx;
          end else if (scan_idx != LAST_IDX) begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_FREAD: begin
          if (!pend_vld || out_free) begin
            if (pend_vld) begin
              slot             <= pend_slot;
              hit              <= 1'b0;
              writeback_valid  <= 1'b1;
              writeback_sector <= pend_sector;
              flush_due        <= 1'b0;
              last             <= 1'b0;
            end
            pend_vld    <= 1'b1;
            pend_slot   <= slot_q;
            pend_sector <= ram_rdata;
            if (scan_idx != LAST_IDX) begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
        end
        ST_FEND: begin
          if (out_free) begin
            slot             <= pend_vld ? pend_slot : '0;
            hit              <= 1'b0;
            writeback_valid  <= pend_vld;
            writeback_sector <= pend_vld ? pend_sector : '0;
            flush_due        <= 1'b0;
            last             <= 1'b1;
            pend_vld         <= 1'b0;
            if (halt_q) begin
              entry_valid     <= '0;
              entry_reference <= '0;
              entry_dirty     <= '0;
              clock_hand      <= '0;
            end
          end
        end
        default: begin
          pend_vld <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/sector_cache_clock_tags_top_tb.sv =====
`timescale 1ns / 1ps
module sector_cache_clock_tags_top_tb;
  import scct_pkg::*;

  localparam int SLOTS = 64;
  localparam int SECTOR_W = 32;
  localparam int POOL_SIZE = 96;
  localparam int HOT_SIZE = 8;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_LIMIT = 100;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [5:0]          slot;
    logic                hit;
    logic                wb_valid;
    logic [SECTOR_W-1:0] wb_sector;
    logic                due;
    logic                last;
  } cache_reply_t;

  class clock_cache_scoreboard;
    bit                  slot_valid [SLOTS];
    logic [SECTOR_W-1:0] slot_sector [SLOTS];
    bit                  slot_ref [SLOTS];
    bit                  slot_dirty [SLOTS];
    int unsigned         hand;
    int unsigned         used;
    logic [WCNT_W-1:0]   wr_tally;
    logic [WCNT_W-1:0]   threshold;
    cache_reply_t        awaited_replies [$];
    int                  mismatches;

    function new();
      int i;
      for (i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 0;
        slot_sector[i] = '0;
        slot_ref[i] = 0;
        slot_dirty[i] = 0;
      end
      hand = 0;
      used = 0;
      wr_tally = '0;
      threshold = THRESH_RESET;
      mismatches = 0;
    endfunction

    function void set_threshold(logic [WCNT_W-1:0] value);
      threshold = value;
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("error at %0t ns: %s", $time, what);
    endtask

    function void predict_access(logic [SECTOR_W-1:0] s, bit w);
      cache_reply_t r;
      int found;
      int h;
      int i;
      r = '0;
      r.last = 1'b1;
      found = -1;
      for (i = 0; i < SLOTS; i++)
        if (found < 0 && slot_valid[i] && slot_sector[i] == s) found = i;
      if (found >= 0) begin
        r.hit = 1'b1;
        r.slot = found[5:0];
        slot_ref[found] = 1;
        if (w) slot_dirty[found] = 1;
      end else begin
        if (used < SLOTS) begin
          for (i = 0; i < SLOTS; i++)
            if (found < 0 && !slot_valid[i]) found = i;
          used++;
        end else begin
          while (found < 0) begin
            h = hand;
            hand = (h + 1) % SLOTS;
            if (!slot_ref[h]) found = h;
            else slot_ref[h] = 0;
          end
          if (slot_dirty[found]) begin
            r.wb_valid = 1'b1;
            r.wb_sector = slot_sector[found];
          end
        end
        r.slot = found[5:0];
        slot_valid[found] = 1;
        slot_sector[found] = s;
        slot_ref[found] = 1;
        slot_dirty[found] = w;
      end
      if (w) begin
        if (wr_tally != WCNT_MAX) wr_tally++;
        if (wr_tally >= threshold) begin
          r.due = 1'b1;
          wr_tally = '0;
        end
      end
      awaited_replies.push_back(r);
    endfunction

    function void predict_flush(bit halt);
      cache_reply_t r;
      int n;
      int i;
      n = 0;
      for (i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_dirty[i]) begin
          r = '0;
          r.slot = i[5:0];
          r.wb_valid = 1'b1;
          r.wb_sector = slot_sector[i];
          awaited_replies.push_back(r);
          slot_dirty[i] = 0;
          n++;
        end
      end
      if (n == 0) begin
        r = '0;
        r.last = 1'b1;
        awaited_replies.push_back(r);
      end else begin
        r = awaited_replies.pop_back();
        r.last = 1'b1;
        awaited_replies.push_back(r);
      end
      if (halt) begin
        for (i = 0; i < SLOTS; i++) begin
          slot_valid[i] = 0;
          slot_ref[i] = 0;
          slot_dirty[i] = 0;
        end
        hand = 0;
        used = 0;
      end
    endfunction

    function void note_command(logic [1:0] c, logic [SECTOR_W-1:0] s, logic w);
      case (c)
        CMD_ACCESS: predict_access(s, w);
        CMD_FLUSH:  predict_flush(1'b0);
        CMD_HALT:   predict_flush(1'b1);
        default: ;
      endcase
    endfunction

    task check_transfer(cache_reply_t got);
      cache_reply_t want;
      string diffs;
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("reply with none awaited: slot %0d hit %0b wb %0b %h last %0b",
                                  got.slot, got.hit, got.wb_valid, got.wb_sector, got.last));
        return;
      end
      want = awaited_replies.pop_front();
      diffs = "";
      if (got.slot !== want.slot)
        diffs = {diffs, $sformatf(" slot %0d/%0d", got.slot, want.slot)};
      if (got.hit !== want.hit)
        diffs = {diffs, $sformatf(" hit %0b/%0b", got.hit, want.hit)};
      if (got.wb_valid !== want.wb_valid)
        diffs = {diffs, $sformatf(" writeback_valid %0b/%0b", got.wb_valid, want.wb_valid)};
      if (got.wb_sector !== want.wb_sector)
        diffs = {diffs, $sformatf(" writeback_sector %h/%h", got.wb_sector, want.wb_sector)};
      if (got.due !== want.due)
        diffs = {diffs, $sformatf(" flush_due %0b/%0b", got.due, want.due)};
      if (got.last !== want.last)
        diffs = {diffs, $sformatf(" last %0b/%0b", got.last, want.last)};
      if (diffs != "") report_mismatch({"reply differs (got/exp):", diffs});
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WCNT_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          cmd = CMD_ACCESS;
  logic [SECTOR_W-1:0] sector = '0;
  logic                is_write = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [5:0]          slot;
  logic                hit;
  logic                writeback_valid;
  logic [SECTOR_W-1:0] writeback_sector;
  logic                flush_due;
  logic                last;

  clock_cache_scoreboard sb;
  logic [SECTOR_W-1:0]   sector_pool [POOL_SIZE];
  bit                    feed_calm = 0;
  bit                    drain_calm = 0;
  int                    hold_off_cycles = 0;
  int                    stall_count = 0;

  sector_cache_clock_tags_top dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .sector           (sector),
    .is_write         (is_write),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .slot             (slot),
    .hit              (hit),
    .writeback_valid  (writeback_valid),
    .writeback_sector (writeback_sector),
    .flush_due        (flush_due),
    .last             (last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else if (stall_count + 1 >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic push_command(input logic [1:0] c, input logic [SECTOR_W-1:0] s,
                              input logic w);
    int gap;
    gap = feed_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    sector <= s;
    is_write <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_command(c, s, w);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_threshold(input logic [WCNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    sb.set_threshold(value);
  endtask

  task automatic run_random_batch(input int quota, input int write_pct, input bit squeeze);
    int counted;
    int pick;
    int src;
    logic [1:0] c;
    logic [SECTOR_W-1:0] s;
    logic w;
    counted = 0;
    if (squeeze) hold_off_cycles = HOLD_OFF_CYCLES;
    while (counted < quota) begin
      pick = $urandom_range(0, 199);
      if (pick == 0) c = CMD_HALT;
      else if (pick < 8) c = CMD_FLUSH;
      else if (pick < 12) c = CMD_UNUSED;
      else c = CMD_ACCESS;
      src = $urandom_range(0, 99);
      if (src < 20) s = sector_pool[$urandom_range(0, HOT_SIZE - 1)];
      else if (src < 85) s = sector_pool[$urandom_range(0, POOL_SIZE - 1)];
      else s = $urandom;
      w = ($urandom_range(0, 99) < write_pct);
      if ($urandom_range(0, 24) == 0) feed_calm = !feed_calm;
      push_command(c, s, w);
      if (c != CMD_UNUSED) counted++;
    end
  endtask

  initial begin
    int gap;
    cache_reply_t seen;
    wait (rst == 1'b0);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      if ($urandom_range(0, 19) == 0) drain_calm = !drain_calm;
      gap = drain_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      seen.slot = slot;
      seen.hit = hit;
      seen.wb_valid = writeback_valid;
      seen.wb_sector = writeback_sector;
      seen.due = flush_due;
      seen.last = last;
      sb.check_transfer(seen);
    end
  end

  initial begin
    int i;
    sb = new();
    for (i = 0; i < POOL_SIZE; i++) sector_pool[i] = $urandom;
    sector_pool[HOT_SIZE] = '0;
    sector_pool[HOT_SIZE + 1] = '1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_command(CMD_ACCESS, 32'h0000_0000, 1'b0);
    push_command(CMD_ACCESS, 32'hFFFF_FFFF, 1'b1);
    push_command(CMD_ACCESS, 32'h0000_0000, 1'b1);
    push_command(CMD_ACCESS, 32'hFFFF_FFFF, 1'b0);
    push_command(CMD_ACCESS, 32'hAAAA_AAAA, 1'b1);
    push_command(CMD_ACCESS, 32'h5555_5555, 1'b0);
    push_command(CMD_UNUSED, 32'h1234_5678, 1'b1);
    push_command(CMD_FLUSH, 32'hFFFF_FFFF, 1'b0);
    push_command(CMD_FLUSH, 32'h0000_0000, 1'b1);
    push_command(CMD_ACCESS, 32'h5555_5555, 1'b1);
    push_command(CMD_HALT, 32'h0000_0000, 1'b0);
    push_command(CMD_HALT, 32'hFFFF_FFFF, 1'b1);
    push_command(CMD_ACCESS, 32'h0000_0000, 1'b1);
    push_command(CMD_ACCESS, 32'h0000_0000, 1'b1);
    settle();

    load_threshold(8'd1);
    run_random_batch(60, 40, 1'b0);
    settle();
    load_threshold(WCNT_W'($urandom_range(2, 254)));
    run_random_batch(70, 50, 1'b1);
    settle();
    load_threshold(8'd255);
    run_random_batch(170, 90, 1'b0);
    settle();
    load_threshold(WCNT_W'($urandom_range(2, 20)));
    run_random_batch(60, 40, 1'b0);
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
